FILE: design/dht_pkg.sv
// Shared types and constants for the double-hashing table.
`timescale 1ns / 1ps

package dht_pkg;

   localparam int KEY_W      = 16;   // key width
   localparam int STATUS_W   = 2;    // result status width
   localparam int SLOT_OUT_W = 6;    // slot field width on the result bus
   localparam int DIV_STEPS  = 3;    // remainder stages: estimate, back-multiply, correct
   localparam int DIV_CNT_W  = 2;    // holds DIV_STEPS
   localparam int RSP_DATA_W = 8;    // status + slot, one byte

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 2'd0,
      ST_FULL      = 2'd1,
      ST_FOUND     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic clear;        // clearing pass, one slot per cycle
      logic load_item;    // latch op/key, start key remainders
      logic div_step;     // advance the remainder pipeline one stage
      logic load_stride;  // save home slot, start stride reduction
      logic probe_start;  // save reduced stride, point at home slot
      logic probe_issue;  // issue one table read, advance probe
      logic capture;      // latch result, write slot on a successful insert
      logic emit;         // load result into output register
   } dht_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_last;
      logic div_last;
      logic hit;
      logic probe_last;
      logic out_free;
   } dht_sts_type;

endpackage

FILE: design/dht_ctrl.sv
// Sequencing state machine for the double-hashing table.
`timescale 1ns / 1ps

module dht_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  dht_pkg::dht_sts_type sts,
   output dht_pkg::dht_cmd_type cmd
);
   import dht_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD_KEY,
      S_STRIDE_LOAD,
      S_MOD_STRIDE,
      S_PROBE_START,
      S_PROBE,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = S_MOD_KEY;
            end
         end
         S_MOD_KEY: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_STRIDE_LOAD;
         end
         S_STRIDE_LOAD: begin
            cmd.load_stride = 1'b1;
            state_in        = S_MOD_STRIDE;
         end
         S_MOD_STRIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_PROBE_START;
         end
         S_PROBE_START: begin
            cmd.probe_start = 1'b1;
            state_in        = S_PROBE;
         end
         S_PROBE: begin
            cmd.probe_issue = 1'b1;
            if (sts.hit || sts.probe_last) begin
               cmd.capture = 1'b1;
               state_in    = S_FINISH;
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/dht_datapath.sv
// Remainder unit, probe address generator, slot memory and result registers.
`timescale 1ns / 1ps

module dht_datapath #(
   parameter int SLOTS      = 64,
   parameter int SECOND_MOD = 13
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_op,
   input  logic [dht_pkg::KEY_W-1:0]       req_key,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [dht_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  dht_pkg::dht_cmd_type            cmd,
   output dht_pkg::dht_sts_type            sts
);
   import dht_pkg::*;

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;       // slot index width
   localparam int MW = $clog2(SECOND_MOD);                    // key mod SECOND_MOD
   localparam int TW = $clog2(SECOND_MOD + 1);                // stride width
   localparam int RS = KEY_W + 1;                             // reciprocal scale bits
   localparam int PW = KEY_W + RS;                            // reciprocal product width
   localparam logic [RS-1:0] RCP_A = RS'((1 << RS) / SLOTS);       // floor(2^RS / SLOTS)
   localparam logic [RS-1:0] RCP_B = RS'((1 << RS) / SECOND_MOD);  // floor(2^RS / SECOND_MOD)

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
   } entry_type;

   entry_type mem [SLOTS];

   // control registers
   logic [SW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 rd_vld_ff;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;

   // payload registers
   logic                  op_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [KEY_W-1:0]      dvd_ff;      // dividend: key, then stride
   logic [KEY_W-1:0]      qa_ff;       // quotient estimates, low by at most one
   logic [KEY_W-1:0]      qb_ff;
   logic [KEY_W-1:0]      fa_ff;       // partial remainders, below twice the modulus
   logic [KEY_W-1:0]      fb_ff;
   logic [SW-1:0]         ra_ff;
   logic [MW-1:0]         rb_ff;
   logic [SW-1:0]         home_ff;
   logic [SW-1:0]         stp_ff;
   logic [SW-1:0]         pos_ff;
   logic [SW-1:0]         rd_addr_ff;
   logic [SW-1:0]         chk_cnt_ff;
   entry_type             rd_ff;
   status_type            pend_status_ff;
   logic [SLOT_OUT_W-1:0] pend_slot_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // reciprocal remainder, one stage per div_step: estimate the quotient,
   // multiply back and subtract, then one conditional correction
   logic [PW-1:0]    prod_a, prod_b;
   logic [KEY_W-1:0] qa_in, qb_in;
   logic [KEY_W-1:0] fa_in, fb_in;
   logic [SW-1:0]    ra_in;
   logic [MW-1:0]    rb_in;
   logic [TW-1:0]    stride_raw;

   always_comb begin
      prod_a = PW'(dvd_ff) * PW'(RCP_A);
      prod_b = PW'(dvd_ff) * PW'(RCP_B);
      qa_in  = prod_a[PW-1:RS];
      qb_in  = prod_b[PW-1:RS];
      fa_in  = dvd_ff - qa_ff * KEY_W'(SLOTS);
      fb_in  = dvd_ff - qb_ff * KEY_W'(SECOND_MOD);
      if (fa_ff >= KEY_W'(SLOTS)) ra_in = SW'(fa_ff - KEY_W'(SLOTS));
      else                        ra_in = SW'(fa_ff);
      if (fb_ff >= KEY_W'(SECOND_MOD)) rb_in = MW'(fb_ff - KEY_W'(SECOND_MOD));
      else                             rb_in = MW'(fb_ff);
      stride_raw = TW'(SECOND_MOD) - TW'(rb_ff);
   end

   // next probe address: (pos + stride) mod SLOTS, stride already reduced
   logic [SW:0]   pos_sum;
   logic [SW-1:0] pos_next;

   always_comb begin
      pos_sum = {1'b0, pos_ff} + {1'b0, stp_ff};
      if (pos_sum >= (SW+1)'(SLOTS)) pos_next = SW'(pos_sum - (SW+1)'(SLOTS));
      else                           pos_next = pos_sum[SW-1:0];
   end

   // probe check on the registered read data
   logic hit;
   logic probe_last;

   always_comb begin
      if (op_ff == OP_INSERT) hit = rd_vld_ff && !rd_ff.valid;
      else                    hit = rd_vld_ff && rd_ff.valid && (rd_ff.key == key_ff);
      probe_last = rd_vld_ff && (chk_cnt_ff == SW'(SLOTS - 1));
   end

   // memory write port: clearing pass or insert
   logic          mem_we;
   logic [SW-1:0] mem_wa;
   entry_type     mem_wd;

   always_comb begin
      mem_we = 1'b0;
      mem_wa = rd_addr_ff;
      mem_wd = '{valid: 1'b1, key: key_ff};
      if (cmd.clear) begin
         mem_we = 1'b1;
         mem_wa = clr_cnt_ff;
         mem_wd = '0;
      end else if (cmd.capture && hit && (op_ff == OP_INSERT)) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_ff <= mem[pos_ff];
   end

   // control register next values
   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      if (cmd.clear) clr_cnt_in = clr_cnt_ff + 1'b1;

      div_cnt_in = div_cnt_ff;
      if (cmd.load_item)        div_cnt_in = DIV_CNT_W'(DIV_STEPS);
      else if (cmd.load_stride) div_cnt_in = DIV_CNT_W'(DIV_STEPS);
      else if (cmd.div_step)    div_cnt_in = div_cnt_ff - 1'b1;

      rsp_tvalid_in = rsp_tvalid_ff;
      if (cmd.emit)        rsp_tvalid_in = 1'b1;
      else if (rsp_tready) rsp_tvalid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff    <= '0;
         div_cnt_ff    <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         clr_cnt_ff    <= clr_cnt_in;
         div_cnt_ff    <= div_cnt_in;
         rd_vld_ff     <= cmd.probe_issue;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff  <= req_op;
         key_ff <= req_key;
         dvd_ff <= req_key;
      end else if (cmd.load_stride) begin
         home_ff <= ra_ff;
         dvd_ff  <= KEY_W'(stride_raw);
      end else if (cmd.div_step) begin
         qa_ff <= qa_in;
         qb_ff <= qb_in;
         fa_ff <= fa_in;
         fb_ff <= fb_in;
         ra_ff <= ra_in;
         rb_ff <= rb_in;
      end

      if (cmd.probe_start) begin
         stp_ff     <= ra_ff;
         pos_ff     <= home_ff;
         chk_cnt_ff <= '0;
      end else if (cmd.probe_issue) begin
         pos_ff     <= pos_next;
         rd_addr_ff <= pos_ff;
         if (rd_vld_ff) chk_cnt_ff <= chk_cnt_ff + 1'b1;
      end

      if (cmd.capture) begin
         if (op_ff == OP_INSERT) begin
            pend_status_ff <= hit ? ST_INSERTED : ST_FULL;
         end else begin
            pend_status_ff <= hit ? ST_FOUND : ST_NOT_FOUND;
         end
         pend_slot_ff <= hit ? SLOT_OUT_W'(rd_addr_ff) : '0;
      end

      if (cmd.emit) rsp_data_ff <= {pend_slot_ff, pend_status_ff};
   end

   always_comb begin
      sts.clr_last   = (clr_cnt_ff == SW'(SLOTS - 1));
      sts.div_last   = (div_cnt_ff == DIV_CNT_W'(1));
      sts.hit        = hit;
      sts.probe_last = probe_last;
      sts.out_free   = !rsp_tvalid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: design/double_hashing_table.sv
// Top level of the open-addressed double-hashing table.
// From accept to rsp_tvalid: two three-stage reciprocal remainders (key, then stride), probe
// setup, then one table read per probe over n = 1..SLOTS slots. One transaction at a time:
// a new request is taken only once the result is in the output register, which waits while
// a previous result is held by rsp_tready. Reset (synchronous, active high) starts a pass
// that clears the slot memory; req_tready stays low until the pass ends.
`timescale 1ns / 1ps

module double_hashing_table #(
   parameter int SLOTS      = 64,   // table slots, 2..64
   parameter int SECOND_MOD = 13    // second hash modulus, 2..251
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] key
   input  logic        req_tuser,   // [0] op: 0 insert, 1 search
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [1:0] status, [7:2] slot
);
   import dht_pkg::*;

   dht_cmd_type cmd;   // controller commands to the datapath
   dht_sts_type sts;   // datapath status back to the controller

   // Controller: clearing pass, key/stride reduction, probe loop, result handoff.
   dht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath: pipelined reciprocal remainders, probe address walk with one read
   // per cycle, slot memory holding {valid, key}, and the output register that
   // decouples the result from the next request.
   dht_datapath #(
      .SLOTS      (SLOTS),
      .SECOND_MOD (SECOND_MOD)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_op     (req_tuser),
      .req_key    (req_tdata[KEY_W-1:0]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

FILE: sim/tb_double_hashing_table.sv
// Self-checking testbench for the double-hashing table: directed and random traffic.
`timescale 1ns / 1ps

module tb_double_hashing_table;
   import dht_pkg::*;

   localparam int SLOTS          = 64;
   localparam int SECOND_MOD     = 13;
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction on either side
   localparam int DRAIN_CYCLES   = 100;   // cycles waited once all results are in
   localparam int RANDOM_ITEMS   = 630;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      status_type      status;
      logic [5:0]      slot;
   } table_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [15:0] key
   logic        req_tuser = 1'b0; // [0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [7:0]  rsp_tdata;        // [1:0] status, [7:2] slot

   // shadow copy of the table
   logic [15:0] shadow_keys [SLOTS];
   bit          shadow_used [SLOTS];

   table_result_type pending_results[$];
   logic [15:0]      stored_keys[$];

   int  error_count = 0;
   int  mismatch_count = 0;
   int  idle_cycles = 0;
   int  stall_left = 0;
   bit  send_steady = 1'b0;
   bit  rsp_steady = 1'b0;
   int  n_inserted = 0, n_full = 0, n_found = 0, n_missing = 0;

   double_hashing_table #(
      .SLOTS      (SLOTS),
      .SECOND_MOD (SECOND_MOD)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one insert/search to the shadow table and returns what the block must answer.
   function automatic table_result_type apply_table_op(logic op, logic [15:0] key);
      table_result_type res;
      int unsigned      home;
      int unsigned      stride;
      int unsigned      s;
      home   = key % SLOTS;
      stride = SECOND_MOD - (key % SECOND_MOD);
      res.status = (op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
      res.slot   = '0;
      // home slot first, then probes 0..SLOTS-1 (probe 0 revisits home)
      for (int i = -1; i < SLOTS; i++) begin
         s = (i < 0) ? home : (home + i * stride) % SLOTS;
         if (op == OP_INSERT && !shadow_used[s]) begin
            shadow_used[s] = 1'b1;
            shadow_keys[s] = key;
            res.status = ST_INSERTED;
            res.slot   = s[5:0];
            break;
         end
         if (op == OP_SEARCH && shadow_used[s] && shadow_keys[s] == key) begin
            res.status = ST_FOUND;
            res.slot   = s[5:0];
            break;
         end
      end
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Drives one request and waits for its handshake; predicts the answer on accept.
   task automatic send_request(logic op, logic [15:0] key);
      int               gap;
      table_result_type res;
      gap = send_steady ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= key;
      do @(posedge clock); while (!req_tready);
      res = apply_table_op(op, key);
      pending_results.push_back(res);
      if (res.status == ST_INSERTED) stored_keys.push_back(key);
      case (res.status)
         ST_INSERTED:  n_inserted++;
         ST_FULL:      n_full++;
         ST_FOUND:     n_found++;
         default:      n_missing++;
      endcase
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Result side: random stalls, with steady stretches when rsp_steady is set.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!rsp_steady && $urandom_range(0, 99) < 25) begin
         stall_left = pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result checker.
   always @(posedge clock) begin
      table_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result: status %0d slot %0d",
                        rsp_tdata[1:0], rsp_tdata[7:2]);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[1:0] !== want.status || rsp_tdata[7:2] !== want.slot) begin
               error_count++;
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                           want.status, want.slot, rsp_tdata[1:0], rsp_tdata[7:2]);
            end
         end
      end
   end

   // Watchdog: no transaction on either side for too long ends the run.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("tb_double_hashing_table: done, errors");
         $finish;
      end
   end

   task automatic test_empty_search();
      send_request(OP_SEARCH, 16'h0000);
      send_request(OP_SEARCH, 16'hFFFF);
   endtask

   task automatic test_insert_and_find();
      send_request(OP_INSERT, 16'h0000);   // home slot 0
      send_request(OP_INSERT, 16'hFFFF);   // home slot 63
      send_request(OP_INSERT, 16'h0000);   // duplicate, probes past home
      send_request(OP_INSERT, 16'd1024);   // home collides with key 0
      send_request(OP_SEARCH, 16'h0000);
      send_request(OP_SEARCH, 16'hFFFF);
      send_request(OP_SEARCH, 16'd1024);
      send_request(OP_SEARCH, 16'd13);     // stride of a full SECOND_MOD
   endtask

   // Key 5 strides by 8, so its probes only cover 8 slots; once those are taken the
   // insert must report full although most of the table is empty.
   task automatic test_partial_cover();
      for (int n = 0; n < 8; n++) send_request(OP_INSERT, 16'd5);
      send_request(OP_SEARCH, 16'd5);
      send_request(OP_SEARCH, 16'd69);     // same home, different stride, absent
   endtask

   task automatic test_random_traffic();
      logic        op;
      logic [15:0] key;
      int          r;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // alternate chunks of idling and back-to-back traffic
         if (n % 50 == 0) begin
            send_steady = ((n / 50) % 3 == 2);
            rsp_steady  = send_steady;
         end
         if (n == RANDOM_ITEMS / 2) wait_results_drained();
         op = ($urandom_range(0, 99) < 20) ? OP_INSERT : OP_SEARCH;
         r  = $urandom_range(0, 99);
         if (r < 45 && stored_keys.size() != 0)
            key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
         else if (r < 70)
            key = $urandom_range(0, 255);   // dense keys collide on home slots
         else
            key = $urandom_range(0, 65535);
         send_request(op, key);
      end
      send_steady = 1'b0;
      rsp_steady  = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_search();
      test_insert_and_find();
      test_partial_cover();
      wait_results_drained();
      test_random_traffic();
      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_results.size() != 0) error_count++;
      $display("covered %0d inserts, %0d table-full, %0d found, %0d not-found answers",
               n_inserted, n_full, n_found, n_missing);
      $display("%0d of %0d slots occupied at the end, %0d mismatches",
               stored_keys.size(), SLOTS, mismatch_count);
      if (error_count == 0)
         $display("tb_double_hashing_table: done, clean");
      else
         $display("tb_double_hashing_table: done, errors");
      $finish;
   end

endmodule

FILE: files.f
design/dht_pkg.sv
design/dht_ctrl.sv
design/dht_datapath.sv
design/double_hashing_table.sv
sim/tb_double_hashing_table.sv
